[rtl/u8d_pkg.sv]
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and codes for the UTF-8 byte decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int unsigned CP_W = 21;

    typedef enum logic [1:0] {
        KIND_OK       = 2'd0,
        KIND_BAD_LEAD = 2'd1,
        KIND_BAD_CONT = 2'd2
    } t_kind;

    typedef struct packed {
        logic            emit;
        t_kind           kind;
        logic [CP_W-1:0] code_point;
        logic [CP_W-1:0] partial;
        logic [1:0]      pending;
    } t_step;

endpackage

[rtl/utf8_byte_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_byte_decoder
// Streaming UTF-8 decoder, one byte per request in, one code point or error out.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the output is not stalled and emits a code
// point when a character completes, or an error kind for a bad lead or bad
// continuation byte; continuation bytes that only advance a character produce
// no output. An input register and a result register surround a single
// decode step; a stalled output holds the input register. tuser on the
// input marks a string start and clears any pending character first.
module utf8_byte_decoder
    import u8d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tuser,   // [0] string_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_axis_tuser    // [1:0] result_kind
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_start;
    logic [CP_W-1:0] r_partial;
    logic [1:0]      r_pending;
    logic            r_out_valid;
    t_kind           r_out_kind;
    logic [CP_W-1:0] r_out_cp;

    logic  w_out_free;
    logic  w_adv;
    t_step n_step;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    u8d_step u_step (
        .i_byte    (r_in_byte),
        .i_start   (r_in_start),
        .i_partial (r_partial),
        .i_pending (r_pending),
        .o_step    (n_step)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_partial   <= '0;
            r_pending   <= 2'd0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (s_axis_tready && s_axis_tvalid) begin
                r_in_byte  <= s_axis_tdata;
                r_in_start <= s_axis_tuser;
            end
            if (w_adv && n_step.emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_adv) begin
                r_partial <= n_step.partial;
                r_pending <= n_step.pending;
                if (n_step.emit) begin
                    r_out_kind  <= n_step.kind;
                    r_out_cp    <= n_step.code_point;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out_cp};
    assign m_axis_tuser  = r_out_kind;

endmodule

[rtl/u8d_step.sv]
// ----------------------------------------------------------------------------
// u8d_step
// One decode step: next partial value, pending count and optional result.
// ----------------------------------------------------------------------------
module u8d_step
    import u8d_pkg::*;
(
    input  logic [7:0]      i_byte,
    input  logic            i_start,
    input  logic [CP_W-1:0] i_partial,
    input  logic [1:0]      i_pending,
    output t_step           o_step
);

    logic [CP_W-1:0] w_partial;
    logic [1:0]      w_pending;
    logic [CP_W-1:0] w_shifted;

    assign w_partial = i_start ? '0 : i_partial;
    assign w_pending = i_start ? 2'd0 : i_pending;
    assign w_shifted = {w_partial[CP_W-7:0], i_byte[5:0]};

    always_comb begin
        o_step.emit       = 1'b0;
        o_step.kind       = KIND_OK;
        o_step.code_point = '0;
        o_step.partial    = '0;
        o_step.pending    = 2'd0;
        if (w_pending == 2'd0) begin
            if (i_byte[7] == 1'b0) begin
                o_step.emit       = 1'b1;
                o_step.code_point = {{(CP_W-8){1'b0}}, i_byte};
            end else if (i_byte[7:5] == 3'b110) begin
                o_step.partial = {{(CP_W-5){1'b0}}, i_byte[4:0]};
                o_step.pending = 2'd1;
            end else if (i_byte[7:4] == 4'b1110) begin
                o_step.partial = {{(CP_W-4){1'b0}}, i_byte[3:0]};
                o_step.pending = 2'd2;
            end else if (i_byte[7:3] == 5'b11110) begin
                o_step.partial = {{(CP_W-3){1'b0}}, i_byte[2:0]};
                o_step.pending = 2'd3;
            end else begin
                o_step.emit = 1'b1;
                o_step.kind = KIND_BAD_LEAD;
            end
        end else if (i_byte[7:6] == 2'b10) begin
            if (w_pending == 2'd1) begin
                o_step.emit       = 1'b1;
                o_step.code_point = w_shifted;
            end else begin
                o_step.partial = w_shifted;
                o_step.pending = w_pending - 2'd1;
            end
        end else begin
            o_step.emit = 1'b1;
            o_step.kind = KIND_BAD_CONT;
        end
    end

endmodule

[rtl/u8d_checker.sv]
// ----------------------------------------------------------------------------
// u8d_checker
// Port-level checks for the UTF-8 byte decoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8d_checker
    import u8d_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("output request changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_OK |-> m_axis_tdata == 24'd0)
        else $error("error result carries nonzero code point");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:21] == 3'b000)
        else $error("code point padding not zero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind utf8_byte_decoder u8d_checker u_u8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
